// ===== rtl/core/swfs_pkg.sv =====
// Package for the sliding-window fingerprint set.
// Holds sizes, transaction structs and the sequencer state type; no dependencies.
package swfs_pkg;

  // Number of fingerprints held in the window and stored fingerprint width.
  localparam int WINDOW   = 64;
  localparam int FP_WIDTH = 64;

  // Width of the occupancy count (0..WINDOW).
  localparam int CNT_W = $clog2(WINDOW + 1);

  // Input transaction.
  typedef struct packed {
    logic        kind;
    logic [63:0] fingerprint;
  } swfs_req_t;

  // Result transaction.
  typedef struct packed {
    logic        found;
    logic        evicted_valid;
    logic [63:0] evicted_fingerprint;
  } swfs_rsp_t;

  // Values broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic                shift;
    logic [FP_WIDTH-1:0] key;
  } swfs_bcast_t;

  // Kind codes.
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    SWFS_IDLE,
    SWFS_CMP,
    SWFS_RES
  } swfs_state_t;

endpackage

// ===== rtl/core/sliding_window_fingerprint_set.sv =====
// Top level of the sliding-window fingerprint set.
// Depends on swfs_pkg and swfs_cell.
//
// The fingerprint is latched at the edge that accepts start. In the next
// cycle every cell of a chain of WINDOW cells compares it with its entry and
// registers a hit. In the cycle after that the hits are combined, and an
// insert also shifts the chain by one cell. busy is high in the compare and
// combining steps. The result shows on result for one cycle with
// result_valid, starting at the edge at which busy falls. The receiver cannot
// stall it, and a new start may be given in that same cycle, but none is
// accepted while busy is high. found reflects the window before this
// transaction. The newest entry sits in cell zero; on an insert into a full
// window the entry in the last cell is reported as evicted. Only the low
// FP_WIDTH bits of the fingerprint are kept and compared.
module sliding_window_fingerprint_set import swfs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  swfs_req_t req,
  output logic      result_valid,
  output swfs_rsp_t result
);

  swfs_state_t         state, state_next;
  logic                kind;
  logic [FP_WIDTH-1:0] key;
  logic [CNT_W-1:0]    fill_count, fill_count_next;
  swfs_bcast_t         bcast;
  logic                found;
  logic                full;
  logic                rsp_load;

  logic [FP_WIDTH-1:0] cell_out [WINDOW];
  logic [WINDOW-1:0]   hits;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SWFS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and the controls of each step.
  always_comb begin
    state_next = state;
    rsp_load   = 1'b0;
    case (state)
      SWFS_IDLE: begin
        if (start) begin
          state_next = SWFS_CMP;
        end
      end
      SWFS_CMP: begin
        state_next = SWFS_RES;
      end
      SWFS_RES: begin
        rsp_load   = 1'b1;
        state_next = SWFS_IDLE;
      end
      default: begin
        state_next = SWFS_IDLE;
      end
    endcase
  end

  assign busy = (state != SWFS_IDLE);

  // Request capture.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind <= req.kind;
      key  <= req.fingerprint[FP_WIDTH-1:0];
    end
  end

  assign full        = (fill_count == CNT_W'(WINDOW));
  assign bcast.shift = rsp_load && (kind == KIND_INSERT);
  assign bcast.key   = key;

  // Chain of cells, newest entry in cell zero.
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [FP_WIDTH-1:0] din;
    if (i == 0) begin : g_head
      assign din = key;
    end else begin : g_link
      assign din = cell_out[i-1];
    end
    swfs_cell u_cell (
      .clk  (clk),
      .bcast(bcast),
      .live (fill_count > CNT_W'(i)),
      .din  (din),
      .dout (cell_out[i]),
      .hit  (hits[i])
    );
  end

  assign found = |hits;

  // Occupancy count.
  always_comb begin
    fill_count_next = fill_count;
    if (bcast.shift && !full) begin
      fill_count_next = fill_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else begin
      fill_count <= fill_count_next;
    end
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= rsp_load;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      result.found         <= found;
      result.evicted_valid <= bcast.shift && full;
      if (bcast.shift && full) begin
        result.evicted_fingerprint <= 64'(cell_out[WINDOW-1]);
      end else begin
        result.evicted_fingerprint <= '0;
      end
    end
  end

  // A result only follows the combining step.
  a_result_after_res: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == SWFS_RES)
    else $error("result strobe without a combining step");

  // The count never exceeds the window.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW))
    else $error("fill count beyond window");

  // An eviction happens only from a full window, which stays full.
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.evicted_valid |-> full && $past(full))
    else $error("eviction from a window that was not full");

  // Without eviction the reported fingerprint is zero.
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.evicted_valid |-> result.evicted_fingerprint == '0)
    else $error("nonzero evicted fingerprint without eviction");

endmodule

// ===== rtl/core/swfs_cell.sv =====
// One cell of the fingerprint chain: a stored fingerprint and its comparator.
// Depends on swfs_pkg.
module swfs_cell import swfs_pkg::*; (
  input  logic                clk,
  input  swfs_bcast_t         bcast,
  input  logic                live,
  input  logic [FP_WIDTH-1:0] din,
  output logic [FP_WIDTH-1:0] dout,
  output logic                hit
);

  logic [FP_WIDTH-1:0] entry;

  // The entry takes its newer neighbor's value (the key, in cell zero) on every insert.
  always_ff @(posedge clk) begin
    if (bcast.shift) begin
      entry <= din;
    end
  end

  // Registered match against the key; cells beyond the fill count never hit.
  always_ff @(posedge clk) begin
    hit <= live && (entry == bcast.key);
  end

  assign dout = entry;

endmodule

// ===== test/swfs_checker.sv =====
`timescale 1ns / 1ps
// Checker for the sliding-window fingerprint set: watches the request and result
// channels, predicts every result from its own window model and compares them.
// Depends on swfs_pkg.
module swfs_checker import swfs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  swfs_req_t req,
  input  logic      result_valid,
  input  swfs_rsp_t result,
  output int        fail_count,
  output int        outstanding
);

  // Window contents as the block should hold them, oldest entry at the front.
  logic [FP_WIDTH-1:0] window_model[$];
  // Predicted results, one per accepted transaction, in order.
  swfs_rsp_t           expected_results[$];
  swfs_rsp_t           oldest_expected;
  swfs_rsp_t           predicted;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // Prints one line per mismatch and counts it.
  task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Looks the fingerprint up in the window before this transaction, then applies
  // an insert, evicting the oldest entry when the window is full.
  task automatic predict_result(input swfs_req_t item, output swfs_rsp_t outcome);
    logic [FP_WIDTH-1:0] key;
    key     = item.fingerprint[FP_WIDTH-1:0];
    outcome = '0;
    foreach (window_model[i]) begin
      if (window_model[i] == key) outcome.found = 1'b1;
    end
    if (item.kind == KIND_INSERT) begin
      if (window_model.size() >= WINDOW) begin
        outcome.evicted_valid                        = 1'b1;
        outcome.evicted_fingerprint[FP_WIDTH-1:0]    = window_model.pop_front();
      end
      window_model.push_back(key);
    end
  endtask

  // Results are retired before a transaction accepted at the same edge is predicted.
  always @(posedge clk) begin
    if (rst) begin
      window_model.delete();
      expected_results.delete();
    end else begin
      if (result_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending", result.evicted_fingerprint, '0);
        end else begin
          oldest_expected = expected_results.pop_front();
          if (result.found !== oldest_expected.found)
            report_mismatch("found", 64'(result.found), 64'(oldest_expected.found));
          if (result.evicted_valid !== oldest_expected.evicted_valid)
            report_mismatch("evicted_valid", 64'(result.evicted_valid),
                            64'(oldest_expected.evicted_valid));
          if (result.evicted_fingerprint !== oldest_expected.evicted_fingerprint)
            report_mismatch("evicted_fingerprint", result.evicted_fingerprint,
                            oldest_expected.evicted_fingerprint);
        end
      end
      if (start && !busy) begin
        predict_result(req, predicted);
        expected_results.push_back(predicted);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== test/tb_sliding_window_fingerprint_set.sv =====
`timescale 1ns / 1ps
// Testbench top for the sliding-window fingerprint set: clock, reset, stimulus
// and the final verdict. Depends on swfs_pkg, the block and swfs_checker.
module tb_sliding_window_fingerprint_set;
  import swfs_pkg::*;

  localparam int RANDOM_ITEMS = 1900;
  localparam int CALM_TAIL    = 200;
  localparam int HISTORY_KEEP = 90;
  localparam int CYCLE_LIMIT  = 200000;

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  swfs_req_t req   = '0;
  logic      busy;
  logic      result_valid;
  swfs_rsp_t result;
  int        fail_count;
  int        outstanding;
  int        cycle_count = 0;

  // Recently inserted fingerprints, so that lookups hit entries both still held
  // and already evicted.
  logic [63:0] inserted_history[$];

  always #10 clk = ~clk;

  sliding_window_fingerprint_set u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result)
  );

  swfs_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  // Mix of repeats, tiny values that collide often, extremes and wide random values.
  function automatic logic [63:0] pick_fingerprint();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45 && inserted_history.size() > 0)
      return inserted_history[$urandom_range(0, inserted_history.size() - 1)];
    if (roll < 55) return 64'($urandom_range(0, 3));
    if (roll < 60) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        2: return 64'h8000_0000_0000_0000;
        default: return 64'h7fff_ffff_ffff_ffff;
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  // Offers one transaction and returns in the step of the edge that accepts it.
  task automatic send_request(input logic op, input logic [63:0] fp);
    swfs_req_t item;
    item.kind        = op;
    item.fingerprint = fp;
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
    if (op == KIND_INSERT) begin
      inserted_history.push_back(fp);
      if (inserted_history.size() > HISTORY_KEEP) void'(inserted_history.pop_front());
    end
  endtask

  // Leaves start low for a burst of cycles while noise sits on the request bus.
  task automatic hold_off(input int cycles);
    start <= 1'b0;
    req   <= {1'($urandom), $urandom, $urandom};
    repeat (cycles) @(posedge clk);
  endtask

  // Stimulus and verdict.
  initial begin
    int idle_pct;
    int waited;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty window, duplicates, extremes and near misses.
    send_request(KIND_LOOKUP, '0);
    send_request(KIND_LOOKUP, '1);
    send_request(KIND_INSERT, '0);
    send_request(KIND_INSERT, '0);
    send_request(KIND_LOOKUP, '0);
    send_request(KIND_INSERT, '1);
    hold_off(3);
    send_request(KIND_LOOKUP, '1);
    send_request(KIND_INSERT, 64'h8000_0000_0000_0000);
    send_request(KIND_LOOKUP, 64'h7fff_ffff_ffff_ffff);
    send_request(KIND_LOOKUP, 64'h0000_0000_0000_0001);
    send_request(KIND_INSERT, 64'h5555_5555_5555_5555);
    send_request(KIND_INSERT, 64'haaaa_aaaa_aaaa_aaaa);
    send_request(KIND_LOOKUP, 64'h5555_5555_5555_5555);
    send_request(KIND_LOOKUP, 64'h8000_0000_0000_0000);

    // Random: idle density changes every 64 transactions, none in the tail.
    idle_pct = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) idle_pct = 25 * $urandom_range(0, 2);
      if (i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(1, 100) <= idle_pct)
        hold_off($urandom_range(1, 11));
      send_request(($urandom_range(0, 99) < 65) ? KIND_INSERT : KIND_LOOKUP,
                   pick_fingerprint());
    end
    start <= 1'b0;

    // Drain the remaining results, then allow a few cycles for strays.
    waited = 0;
    while (outstanding != 0 && waited < 100) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guards against a hang.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
